>>> design/lpl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpl_pkg
// Shared constants, types and helpers for the lookahead peak limiter.
// ----------------------------------------------------------------------------
package lpl_pkg;

  localparam int LANES         = 8;
  localparam int LOOKAHEAD_MAX = 256;
  localparam int WIN_CAP       = LOOKAHEAD_MAX + 1;
  localparam int SAMPLE_BITS   = 24;
  localparam int DRV_BITS      = SAMPLE_BITS + 4;
  localparam int PTR_BITS      = $clog2(LOOKAHEAD_MAX);
  localparam int TIME_BITS     = PTR_BITS + 1;
  localparam int WIN_BITS      = $clog2(WIN_CAP);
  localparam int LEN_BITS      = 9;
  localparam int GAIN_BITS     = 16;
  localparam int CNT_BITS      = 4;
  localparam int DIV_STEPS     = GAIN_BITS - 1;
  localparam int CIDX_BITS     = 3;
  localparam int CDATA_BITS    = 16;

  localparam logic [GAIN_BITS-1:0] UNITY_GAIN = GAIN_BITS'(32768);
  localparam logic [LEN_BITS-1:0]  LEN_MAX    = LEN_BITS'(LOOKAHEAD_MAX);

  // Configuration register indexes
  localparam logic [CIDX_BITS-1:0] REG_MODE    = CIDX_BITS'(0);
  localparam logic [CIDX_BITS-1:0] REG_ACTIVE  = CIDX_BITS'(1);
  localparam logic [CIDX_BITS-1:0] REG_LEN     = CIDX_BITS'(2);
  localparam logic [CIDX_BITS-1:0] REG_CEILING = CIDX_BITS'(3);
  localparam logic [CIDX_BITS-1:0] REG_DRIVE   = CIDX_BITS'(4);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [DRV_BITS-1:0]    driven_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] stamp;
    logic [DRV_BITS-1:0]  mag;
  } win_entry_t;

  // Control shared by every lane
  typedef struct packed {
    logic                  start;
    logic                  clear_en;
    logic [PTR_BITS-1:0]   clear_addr;
    logic [PTR_BITS-1:0]   wp;
    logic [PTR_BITS-1:0]   rd;
    logic [TIME_BITS-1:0]  now;
    logic [LEN_BITS-1:0]   len;
    logic [15:0]           drive;
    logic [GAIN_BITS-1:0]  ceil;
  } lane_ctl_t;

  typedef struct packed {
    logic                 busy;
    logic [GAIN_BITS-1:0] gain;
    driven_t              delayed;
  } lane_stat_t;

  typedef enum logic [7:0] {
    L_IDLE      = 8'b0000_0001,
    L_DRIVE     = 8'b0000_0010,
    L_FRONT_RD  = 8'b0000_0100,
    L_FRONT_CHK = 8'b0000_1000,
    L_BACK_RD   = 8'b0001_0000,
    L_BACK_CHK  = 8'b0010_0000,
    L_PUSH      = 8'b0100_0000,
    L_DIV       = 8'b1000_0000
  } lane_state_t;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_GAIN  = 5'b01000,
    ST_MUL   = 5'b10000
  } top_state_t;

  // Advance a window index modulo WIN_CAP
  function automatic logic [WIN_BITS-1:0] win_inc(input logic [WIN_BITS-1:0] i);
    logic [WIN_BITS-1:0] r;
    r = (i == WIN_BITS'(WIN_CAP - 1)) ? '0 : i + WIN_BITS'(1);
    return r;
  endfunction

  // head + offset modulo WIN_CAP, with both below WIN_CAP
  function automatic logic [WIN_BITS-1:0] win_add(input logic [WIN_BITS-1:0] a,
                                                  input logic [WIN_BITS:0]   b);
    logic [WIN_BITS+1:0] s;
    s = {2'b00, a} + {1'b0, b};
    if (s >= (WIN_BITS + 2)'(WIN_CAP)) begin
      s = s - (WIN_BITS + 2)'(WIN_CAP);
    end
    return s[WIN_BITS-1:0];
  endfunction

endpackage

>>> design/lpl_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpl_lane
// One limiter lane: drive scaling, delay line, monotonic peak window and
// a bit-serial gain divider.
// ----------------------------------------------------------------------------
module lpl_lane
  import lpl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  lane_ctl_t  ctl,
  input  logic       active,
  input  sample_t    sample,
  output lane_stat_t stat
);

  lane_state_t state;
  sample_t     smp;
  driven_t     x;
  driven_t     delayed;
  logic [WIN_BITS-1:0]  head;
  logic [WIN_BITS:0]    fill;
  win_entry_t           rdata;
  logic [DRV_BITS-1:0]  front_mag;
  logic [DRV_BITS-1:0]  peak;
  logic [DRV_BITS-1:0]  rem;
  logic [DIV_STEPS-1:0] quo;
  logic [CNT_BITS-1:0]  cnt;
  logic [GAIN_BITS-1:0] gain;
  logic                 act;

  driven_t    delay_mem [LOOKAHEAD_MAX];
  win_entry_t win_mem   [WIN_CAP];

  logic signed [SAMPLE_BITS+16:0] prod;
  logic [DRV_BITS-1:0]  mag;
  logic [TIME_BITS-1:0] age;
  logic [WIN_BITS-1:0]  back_idx;
  logic [WIN_BITS-1:0]  push_idx;
  logic [WIN_BITS-1:0]  win_ra;
  logic [DRV_BITS-1:0]  peak_next;
  logic [DRV_BITS-1:0]  ceil_scaled;
  logic [DRV_BITS:0]    rem2;
  logic                 dly_we;
  logic [PTR_BITS-1:0]  dly_wa;
  driven_t              dly_wd;

  // Drive scaling and magnitude
  assign prod     = $signed(smp) * $signed({1'b0, ctl.drive});
  assign mag      = x[DRV_BITS-1] ? DRV_BITS'(-x) : DRV_BITS'(x);
  assign age      = ctl.now - rdata.stamp;
  assign back_idx = win_add(head, fill - (WIN_BITS + 1)'(1));
  assign push_idx = win_add(head, fill);
  assign win_ra   = (state == L_FRONT_RD) ? head : back_idx;
  assign peak_next   = (fill == '0) ? mag : front_mag;
  assign ceil_scaled = DRV_BITS'({ctl.ceil, 8'b0});
  assign rem2        = {rem, 1'b0};

  // Delay line write port: clearing sweep, inactive zero, or driven sample
  always_comb begin
    dly_we = 1'b0;
    dly_wa = ctl.wp;
    dly_wd = '0;
    if (state == L_IDLE && ctl.clear_en) begin
      dly_we = 1'b1;
      dly_wa = ctl.clear_addr;
    end else if (state == L_DRIVE && !act) begin
      dly_we = 1'b1;
    end else if (state == L_FRONT_RD) begin
      dly_we = 1'b1;
      dly_wd = x;
    end
  end

  always_ff @(posedge clk) begin
    if (dly_we) begin
      delay_mem[dly_wa] <= dly_wd;
    end
    if (state == L_DRIVE) begin
      delayed <= delay_mem[ctl.rd];
    end
  end

  // Peak window store
  always_ff @(posedge clk) begin
    if (state == L_PUSH) begin
      win_mem[push_idx] <= '{stamp: ctl.now, mag: mag};
    end
    if (state == L_FRONT_RD || state == L_BACK_RD) begin
      rdata <= win_mem[win_ra];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == L_IDLE && ctl.start) begin
      smp <= sample;
      act <= active;
    end
    if (state == L_DRIVE) begin
      x <= prod[DRV_BITS+11:12];
    end
    if (state == L_FRONT_CHK) begin
      front_mag <= rdata.mag;
    end
  end

  // Sequencer: expire front, pop back entries not larger than the new one, push, divide
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      head  <= '0;
      fill  <= '0;
      gain  <= UNITY_GAIN;
      cnt   <= '0;
    end else begin
      case (state)
        L_IDLE: begin
          if (ctl.start) begin
            state <= L_DRIVE;
          end
        end
        L_DRIVE: begin
          if (!act) begin
            head  <= '0;
            fill  <= '0;
            gain  <= UNITY_GAIN;
            state <= L_IDLE;
          end else begin
            state <= L_FRONT_RD;
          end
        end
        L_FRONT_RD: begin
          state <= L_FRONT_CHK;
        end
        L_FRONT_CHK: begin
          if (fill != '0 && age > TIME_BITS'(ctl.len)) begin
            head  <= win_inc(head);
            fill  <= fill - (WIN_BITS + 1)'(1);
            state <= L_FRONT_RD;
          end else if (fill == '0) begin
            state <= L_PUSH;
          end else begin
            state <= L_BACK_RD;
          end
        end
        L_BACK_RD: begin
          state <= L_BACK_CHK;
        end
        L_BACK_CHK: begin
          if (rdata.mag <= mag) begin
            fill <= fill - (WIN_BITS + 1)'(1);
            if (fill == (WIN_BITS + 1)'(1)) begin
              state <= L_PUSH;
            end else begin
              state <= L_BACK_RD;
            end
          end else begin
            state <= L_PUSH;
          end
        end
        L_PUSH: begin
          fill <= fill + (WIN_BITS + 1)'(1);
          peak <= peak_next;
          rem  <= ceil_scaled;
          quo  <= '0;
          cnt  <= CNT_BITS'(DIV_STEPS);
          if (peak_next == '0 || ceil_scaled >= peak_next) begin
            gain  <= UNITY_GAIN;
            state <= L_IDLE;
          end else begin
            state <= L_DIV;
          end
        end
        L_DIV: begin
          // One restoring quotient bit per cycle
          if (rem2 >= {1'b0, peak}) begin
            rem <= DRV_BITS'(rem2 - {1'b0, peak});
            quo <= {quo[DIV_STEPS-2:0], 1'b1};
          end else begin
            rem <= rem2[DRV_BITS-1:0];
            quo <= {quo[DIV_STEPS-2:0], 1'b0};
          end
          cnt <= cnt - CNT_BITS'(1);
          if (cnt == CNT_BITS'(1)) begin
            gain  <= {1'b0, quo[DIV_STEPS-2:0], (rem2 >= {1'b0, peak})};
            state <= L_IDLE;
          end
        end
        default: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

  assign stat.busy    = (state != L_IDLE);
  assign stat.gain    = gain;
  assign stat.delayed = delayed;

endmodule

>>> design/lpl_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpl_merge
// Combines lane gains (independent or linked minimum) and applies them to
// the delayed samples with saturation.
// ----------------------------------------------------------------------------
module lpl_merge
  import lpl_pkg::*;
(
  input  logic       clk,
  input  logic       load,
  input  logic       mode,
  input  logic [3:0] active_ch,
  input  lane_stat_t lane_st [LANES],
  output sample_t    res     [LANES]
);

  logic [GAIN_BITS-1:0] sel_gain [LANES];
  logic                 act_q    [LANES];
  logic [GAIN_BITS-1:0] min_gain;
  logic                 act      [LANES];

  localparam logic signed [DRV_BITS+1:0] SAT_HI =
    (DRV_BITS + 2)'((1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [DRV_BITS+1:0] SAT_LO =
    -(DRV_BITS + 2)'(1 <<< (SAMPLE_BITS - 1));

  // Linked minimum over the active lanes
  always_comb begin
    min_gain = UNITY_GAIN;
    for (int k = 0; k < LANES; k++) begin
      act[k] = (k < int'(active_ch));
      if (act[k] && lane_st[k].gain < min_gain) begin
        min_gain = lane_st[k].gain;
      end
    end
  end

  // Hold the chosen gain per lane
  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < LANES; k++) begin
        sel_gain[k] <= mode ? min_gain : lane_st[k].gain;
        act_q[k]    <= act[k];
      end
    end
  end

  // Apply gain, floor shift and saturate; inactive lanes give zero
  for (genvar k = 0; k < LANES; k++) begin : g_out
    logic signed [DRV_BITS+GAIN_BITS:0] prod;
    logic signed [DRV_BITS+1:0]         y;
    assign prod = lane_st[k].delayed * $signed({1'b0, sel_gain[k]});
    assign y    = $signed(prod[DRV_BITS+GAIN_BITS:15]);
    always_comb begin
      if (!act_q[k]) begin
        res[k] = '0;
      end else if (y > SAT_HI) begin
        res[k] = SAT_HI[SAMPLE_BITS-1:0];
      end else if (y < SAT_LO) begin
        res[k] = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
        res[k] = y[SAMPLE_BITS-1:0];
      end
    end
  end

endmodule

>>> design/lookahead_peak_limiter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lookahead_peak_limiter_unit
// Eight-lane lookahead peak limiter with per-lane delay lines and peak
// windows, iterative gain division and a linked or independent gain merge.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid, in_ready, sample_0..7           | frame in
//  out     | out_valid, out_ready, limited_0..7        | frame out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// One frame at a time. Each lane takes a drive step, a read and a check per window
// entry inspected (each expired front entry and each back entry compared),
// a push and, unless the gain is unity, one divider step per quotient bit; the
// slowest lane sets the pace. Once every lane is idle the sequencer passes
// through ST_GAIN, where the merge takes the gains, and ST_MUL, where the
// result is loaded into the output register. After reset the delay lines are
// swept to zero; no frame is taken meanwhile. A new frame is taken while the
// previous result waits; the merge then holds until the output register frees.
// ----------------------------------------------------------------------------
module lookahead_peak_limiter_unit
  import lpl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sample_t               sample_0,
  input  sample_t               sample_1,
  input  sample_t               sample_2,
  input  sample_t               sample_3,
  input  sample_t               sample_4,
  input  sample_t               sample_5,
  input  sample_t               sample_6,
  input  sample_t               sample_7,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sample_t               limited_0,
  output sample_t               limited_1,
  output sample_t               limited_2,
  output sample_t               limited_3,
  output sample_t               limited_4,
  output sample_t               limited_5,
  output sample_t               limited_6,
  output sample_t               limited_7,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CIDX_BITS-1:0]  cfg_index,
  input  logic [CDATA_BITS-1:0] cfg_data
);

  top_state_t           state;
  logic                 mode;
  logic [3:0]           active_ch;
  logic [LEN_BITS-1:0]  lookahead;
  logic [15:0]          ceiling;
  logic [15:0]          drive;
  logic [PTR_BITS-1:0]  wp;
  logic [TIME_BITS-1:0] now;
  logic [PTR_BITS-1:0]  clr_addr;
  sample_t              limited [LANES];

  sample_t              samples [LANES];
  sample_t              res     [LANES];
  lane_stat_t           lane_st [LANES];
  lane_ctl_t            ctl;
  logic [LEN_BITS-1:0]  len_eff;
  logic                 accept;
  logic                 lanes_busy;
  logic                 out_load;

  assign samples = '{sample_0, sample_1, sample_2, sample_3,
                     sample_4, sample_5, sample_6, sample_7};

  // Clamp lookahead to 1..LEN_MAX; the ceiling is clamped at ctl.ceil
  always_comb begin
    len_eff = lookahead;
    if (lookahead == '0) begin
      len_eff = LEN_BITS'(1);
    end else if (lookahead > LEN_MAX) begin
      len_eff = LEN_MAX;
    end
  end

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = (state == ST_MUL) && (!out_valid || out_ready);

  assign ctl.start      = accept;
  assign ctl.clear_en   = (state == ST_CLEAR);
  assign ctl.clear_addr = clr_addr;
  assign ctl.wp         = wp;
  assign ctl.rd         = wp - len_eff[PTR_BITS-1:0];
  assign ctl.now        = now;
  assign ctl.len        = len_eff;
  assign ctl.drive      = drive;
  assign ctl.ceil       = (ceiling > UNITY_GAIN) ? UNITY_GAIN : ceiling;

  // Lanes
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    lpl_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .active (k < int'(active_ch)),
      .sample (samples[k]),
      .stat   (lane_st[k])
    );
  end

  always_comb begin
    lanes_busy = 1'b0;
    for (int k = 0; k < LANES; k++) begin
      lanes_busy = lanes_busy | lane_st[k].busy;
    end
  end

  lpl_merge u_merge (
    .clk       (clk),
    .load      (state == ST_GAIN),
    .mode      (mode),
    .active_ch (active_ch),
    .lane_st   (lane_st),
    .res       (res)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= 1'b0;
      active_ch <= 4'd2;
      lookahead <= LEN_BITS'(240);
      ceiling   <= 16'd32768;
      drive     <= 16'd4096;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:    mode      <= cfg_data[0];
        REG_ACTIVE:  active_ch <= cfg_data[3:0];
        REG_LEN:     lookahead <= cfg_data[LEN_BITS-1:0];
        REG_CEILING: ceiling   <= cfg_data;
        REG_DRIVE:   drive     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Frame sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      wp       <= '0;
      now      <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + PTR_BITS'(1);
          if (clr_addr == PTR_BITS'(LOOKAHEAD_MAX - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (!lanes_busy) begin
            state <= ST_GAIN;
          end
        end
        ST_GAIN: begin
          wp    <= wp + PTR_BITS'(1);
          now   <= now + TIME_BITS'(1);
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      limited <= res;
    end
  end

  assign limited_0 = limited[0];
  assign limited_1 = limited[1];
  assign limited_2 = limited[2];
  assign limited_3 = limited[3];
  assign limited_4 = limited[4];
  assign limited_5 = limited[5];
  assign limited_6 = limited[6];
  assign limited_7 = limited[7];

`ifndef SYNTH
  a_one_frame: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("frame accepted while another is in flight");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_MUL))
    else $error("result presented without a merge");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

>>> bench/lookahead_peak_limiter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lookahead_peak_limiter_unit_tb
// Self-checking bench for the lookahead peak limiter. A list of frames and
// register writes feeds a clocked driver. A built-in limiter model predicts
// each output frame at input acceptance. A clocked monitor checks every
// output transaction lane by lane. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module lookahead_peak_limiter_unit_tb;
  import lpl_pkg::*;

  localparam int FRAME_W       = LANES * SAMPLE_BITS;
  localparam int TOTAL_FRAMES  = 1350;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int JOB_CAP       = 4096;
  localparam logic [CIDX_BITS-1:0] REG_SPARE = CIDX_BITS'(7);

  typedef logic [FRAME_W-1:0] frame_bits_t;
  typedef enum logic [1:0] {K_FRAME, K_WRITE, K_DRAIN} job_kind_t;
  typedef struct packed {
    job_kind_t              kind;
    frame_bits_t            frame;
    logic [CIDX_BITS-1:0]   idx;
    logic [CDATA_BITS-1:0]  data;
  } job_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready;
  logic out_valid, out_ready = 1'b0;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [CIDX_BITS-1:0]  cfg_index = '0;
  logic [CDATA_BITS-1:0] cfg_data = '0;
  frame_bits_t in_frame = '0;
  sample_t limited_0, limited_1, limited_2, limited_3;
  sample_t limited_4, limited_5, limited_6, limited_7;
  frame_bits_t out_frame;

  assign out_frame = {limited_7, limited_6, limited_5, limited_4,
                      limited_3, limited_2, limited_1, limited_0};

  lookahead_peak_limiter_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .sample_0(in_frame[0*SAMPLE_BITS +: SAMPLE_BITS]),
    .sample_1(in_frame[1*SAMPLE_BITS +: SAMPLE_BITS]),
    .sample_2(in_frame[2*SAMPLE_BITS +: SAMPLE_BITS]),
    .sample_3(in_frame[3*SAMPLE_BITS +: SAMPLE_BITS]),
    .sample_4(in_frame[4*SAMPLE_BITS +: SAMPLE_BITS]),
    .sample_5(in_frame[5*SAMPLE_BITS +: SAMPLE_BITS]),
    .sample_6(in_frame[6*SAMPLE_BITS +: SAMPLE_BITS]),
    .sample_7(in_frame[7*SAMPLE_BITS +: SAMPLE_BITS]),
    .out_valid(out_valid), .out_ready(out_ready),
    .limited_0(limited_0), .limited_1(limited_1),
    .limited_2(limited_2), .limited_3(limited_3),
    .limited_4(limited_4), .limited_5(limited_5),
    .limited_6(limited_6), .limited_7(limited_7),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Clock: 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Limiter model state and registers
  logic        lim_linked;
  logic [3:0]  lim_lanes;
  logic [8:0]  lim_len;
  logic [15:0] lim_ceil;
  logic [15:0] lim_drive;
  longint      delay_line [LANES][LOOKAHEAD_MAX];
  longint      peak_mag   [LANES][WIN_CAP];
  int          peak_stamp [LANES][WIN_CAP];
  int          peak_head  [LANES];
  int          peak_fill  [LANES];
  int          wr_ptr, frame_clock;

  job_t        jobs [JOB_CAP];
  int          job_rd = 0, job_wr = 0;
  frame_bits_t limited_q [JOB_CAP];
  int          lq_rd = 0, lq_wr = 0;
  int          error_count = 0;
  int          frames_sent = 0, frames_checked = 0, writes_done = 0;
  int          cycle_count = 0;
  logic        tail_phase = 1'b0;

  task automatic report(input string what);
    error_count++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  task automatic apply_write(input logic [CIDX_BITS-1:0] idx, input logic [15:0] d);
    case (idx)
      REG_MODE:    lim_linked = d[0];
      REG_ACTIVE:  lim_lanes  = d[3:0];
      REG_LEN:     lim_len    = d[8:0];
      REG_CEILING: lim_ceil   = d;
      REG_DRIVE:   lim_drive  = d;
      default: ;
    endcase
  endtask

  // Push a magnitude into a lane window and return the window peak
  function automatic longint track_peak(input int k, input longint mag, input int now,
                                        input int len);
    int h, f, b;
    h = peak_head[k];
    f = peak_fill[k];
    while (f > 0 && ((now + 2*LOOKAHEAD_MAX - peak_stamp[k][h]) % (2*LOOKAHEAD_MAX)) > len)
    begin
      h = (h + 1) % WIN_CAP;
      f--;
    end
    while (f > 0 && peak_mag[k][(h + f - 1) % WIN_CAP] <= mag) f--;
    if (f >= WIN_CAP) begin
      h = (h + 1) % WIN_CAP;
      f--;
    end
    b = (h + f) % WIN_CAP;
    peak_stamp[k][b] = now;
    peak_mag[k][b] = mag;
    peak_head[k] = h;
    peak_fill[k] = f + 1;
    return peak_mag[k][h];
  endfunction

  // Compute the limited frame that one input frame produces
  function automatic frame_bits_t limit_frame(input frame_bits_t fin);
    frame_bits_t res;
    int          len, rd;
    longint      ceil_v, x, mag, pk, q, y;
    longint      gain [LANES];
    longint      held [LANES];
    logic        on   [LANES];
    longint      min_gain;
    res = '0;
    len = (lim_len < 1) ? 1 : (lim_len > LOOKAHEAD_MAX) ? LOOKAHEAD_MAX : int'(lim_len);
    ceil_v = (lim_ceil > UNITY_GAIN) ? 32768 : longint'(lim_ceil);
    rd = (wr_ptr + LOOKAHEAD_MAX - len) % LOOKAHEAD_MAX;
    min_gain = 32768;
    for (int k = 0; k < LANES; k++) begin
      held[k] = delay_line[k][rd];
      on[k] = (k < lim_lanes);
      gain[k] = 32768;
      if (!on[k]) begin
        delay_line[k][wr_ptr] = 0;
        peak_head[k] = 0;
        peak_fill[k] = 0;
      end else begin
        x = (longint'(sample_t'(fin[k*SAMPLE_BITS +: SAMPLE_BITS])) *
             longint'(lim_drive)) >>> 12;
        delay_line[k][wr_ptr] = x;
        mag = (x < 0) ? -x : x;
        pk = track_peak(k, mag, frame_clock, len);
        if (pk != 0) begin
          q = (ceil_v <<< (SAMPLE_BITS - 1)) / pk;
          gain[k] = (q > 32768) ? 32768 : q;
        end
        if (gain[k] < min_gain) min_gain = gain[k];
      end
    end
    for (int k = 0; k < LANES; k++) begin
      if (on[k]) begin
        y = (held[k] * (lim_linked ? min_gain : gain[k])) >>> 15;
        if (y > 8388607) y = 8388607;
        if (y < -8388608) y = -8388608;
        res[k*SAMPLE_BITS +: SAMPLE_BITS] = y[SAMPLE_BITS-1:0];
      end
    end
    wr_ptr = (wr_ptr + 1) % LOOKAHEAD_MAX;
    frame_clock = (frame_clock + 1) % (2*LOOKAHEAD_MAX);
    return res;
  endfunction

  // Sample generators
  function automatic sample_t pick_sample(input int style);
    case (style)
      0: return sample_t'($urandom);
      1: return sample_t'($urandom_range(2000) - 1000);
      2: return ($urandom_range(1) != 0) ? sample_t'(24'h7FFFFF) : sample_t'(24'h800000);
      default: return sample_t'($urandom_range(8388607, 6000000)) *
                      (($urandom_range(1) != 0) ? sample_t'(1) : sample_t'(-1));
    endcase
  endfunction

  function automatic frame_bits_t fill_frame(input int style);
    frame_bits_t f;
    for (int k = 0; k < LANES; k++) f[k*SAMPLE_BITS +: SAMPLE_BITS] = pick_sample(style);
    return f;
  endfunction

  function automatic frame_bits_t flat_frame(input sample_t v);
    return {LANES{v}};
  endfunction

  task automatic job_put(input job_t j);
    jobs[job_wr] = j;
    job_wr++;
  endtask

  task automatic add_frame(input frame_bits_t f);
    job_put('{K_FRAME, f, '0, '0});
  endtask

  task automatic add_write(input logic [CIDX_BITS-1:0] idx, input int d);
    job_put('{K_WRITE, '0, idx, CDATA_BITS'(d)});
  endtask

  // Driver: frames and register writes
  int   gap_left = 0, quiet_cycles = 0;
  job_t head_job;
  always @(posedge clk) begin
    logic nxt_in_valid, nxt_cfg_valid;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      nxt_in_valid = in_valid;
      nxt_cfg_valid = cfg_valid;
      // accept transactions
      if (in_valid && in_ready) begin
        limited_q[lq_wr] = limit_frame(in_frame);
        lq_wr++;
        frames_sent++;
        nxt_in_valid = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        apply_write(cfg_index, cfg_data);
        writes_done++;
        nxt_cfg_valid = 1'b0;
      end
      quiet_cycles = (lq_rd == lq_wr) ? quiet_cycles + 1 : 0;
      tail_phase <= (frames_sent >= TOTAL_FRAMES - 120);
      // launch the next job
      if (!nxt_in_valid && !nxt_cfg_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (job_rd != job_wr) begin
          head_job = jobs[job_rd];
          if (head_job.kind == K_FRAME) begin
            in_frame <= head_job.frame;
            nxt_in_valid = 1'b1;
            job_rd++;
            if (!tail_phase && $urandom_range(3) == 0) gap_left = $urandom_range(15, 1);
          end else if (quiet_cycles >= SETTLE_CYCLES && !in_valid) begin
            if (head_job.kind == K_WRITE) begin
              cfg_index <= head_job.idx;
              cfg_data <= head_job.data;
              nxt_cfg_valid = 1'b1;
            end
            job_rd++;
          end
        end
      end
      in_valid <= nxt_in_valid;
      cfg_valid <= nxt_cfg_valid;
    end
  end

  // Monitor: check results and stall the output side
  int stall_left = 0;
  always @(posedge clk) begin
    frame_bits_t want;
    logic nxt_ready;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (lq_rd == lq_wr) begin
          report("output transaction with no frame pending");
        end else begin
          want = limited_q[lq_rd];
          lq_rd++;
          frames_checked++;
          for (int k = 0; k < LANES; k++) begin
            if (out_frame[k*SAMPLE_BITS +: SAMPLE_BITS] != want[k*SAMPLE_BITS +: SAMPLE_BITS])
              report($sformatf("frame %0d limited_%0d got %0d want %0d", frames_checked, k,
                               sample_t'(out_frame[k*SAMPLE_BITS +: SAMPLE_BITS]),
                               sample_t'(want[k*SAMPLE_BITS +: SAMPLE_BITS])));
          end
        end
      end
      // hold ready low for a random burst, then release
      if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else if (!tail_phase && $urandom_range(5) == 0) begin
        stall_left = $urandom_range(14);
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      out_ready <= nxt_ready;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    int queued, run_len, style;
    lim_linked = 1'b0;
    lim_lanes = 4'd2;
    lim_len = 9'd240;
    lim_ceil = 16'd32768;
    lim_drive = 16'd4096;
    wr_ptr = 0;
    frame_clock = 0;
    for (int k = 0; k < LANES; k++) begin
      peak_head[k] = 0;
      peak_fill[k] = 0;
      for (int j = 0; j < LOOKAHEAD_MAX; j++) delay_line[k][j] = 0;
    end

    // directed: reset settings, then extremes with window length one
    add_frame(flat_frame(sample_t'(24'h7FFFFF)));
    add_frame(flat_frame(sample_t'(24'h800000)));
    add_frame(flat_frame(sample_t'(0)));
    add_write(REG_ACTIVE, 8);
    add_write(REG_LEN, 1);
    add_write(REG_DRIVE, 65535);
    add_write(REG_CEILING, 32768);
    add_frame(flat_frame(sample_t'(24'h7FFFFF)));
    add_frame(flat_frame(sample_t'(24'h800000)));
    add_frame(flat_frame(sample_t'(-1)));
    add_frame(flat_frame(sample_t'(1)));
    add_frame(flat_frame(sample_t'(0)));
    add_frame(fill_frame(2));
    // ceiling and lane count above range, window length zero, drive off
    add_write(REG_CEILING, 65535);
    add_write(REG_ACTIVE, 15);
    add_write(REG_LEN, 0);
    add_frame(fill_frame(3));
    add_frame(fill_frame(0));
    add_write(REG_DRIVE, 0);
    add_frame(fill_frame(0));
    // linked with a zero ceiling, then no active lane at all
    add_write(REG_MODE, 1);
    add_write(REG_CEILING, 0);
    add_write(REG_DRIVE, 4096);
    add_write(REG_ACTIVE, 3);
    add_frame(fill_frame(3));
    add_frame(fill_frame(0));
    add_write(REG_ACTIVE, 0);
    add_write(REG_SPARE, 16'hFFFF);
    add_frame(fill_frame(0));
    add_frame(fill_frame(2));
    queued = 16;

    // random phases of settings
    while (queued < TOTAL_FRAMES) begin
      add_write(REG_MODE, $urandom_range(1));
      add_write(REG_ACTIVE, ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(8, 1));
      case ($urandom_range(5))
        0: add_write(REG_LEN, 256);
        1: add_write(REG_LEN, $urandom_range(511));
        default: add_write(REG_LEN, $urandom_range(16, 1));
      endcase
      case ($urandom_range(3))
        0: add_write(REG_CEILING, ($urandom_range(1) != 0) ? 0 : 32768);
        1: add_write(REG_CEILING, $urandom_range(65535));
        default: add_write(REG_CEILING, $urandom_range(32768, 4000));
      endcase
      case ($urandom_range(3))
        0: add_write(REG_DRIVE, ($urandom_range(1) != 0) ? 0 : 65535);
        1: add_write(REG_DRIVE, $urandom_range(65535));
        default: add_write(REG_DRIVE, $urandom_range(12000, 2000));
      endcase
      run_len = ($urandom_range(7) == 0) ? $urandom_range(320, 260) : $urandom_range(80, 20);
      if (run_len > TOTAL_FRAMES - queued) run_len = TOTAL_FRAMES - queued;
      style = $urandom_range(3);
      for (int i = 0; i < run_len; i++) begin
        add_frame(fill_frame(($urandom_range(4) == 0) ? $urandom_range(3) : style));
        // wait for the block to empty out mid-phase once in a while
        if ($urandom_range(150) == 0) job_put('{K_DRAIN, '0, '0, '0});
      end
      queued += run_len;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (job_rd == job_wr && !in_valid && !cfg_valid && lq_rd == lq_wr);
    repeat (600) @(posedge clk);
    $display("run covered %0d frames and %0d register writes, %0d outputs checked",
             frames_sent, writes_done, frames_checked);
    $display("modes, lane counts, window lengths 0..511, ceilings and drives swept");
    if (error_count == 0 && lq_rd == lq_wr) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
